/* hdl/multispecies_bgk_guo_collision_assert.svh */
// Assertion macros for the multispecies BGK collision block.
`ifndef MULTISPECIES_BGK_GUO_COLLISION_ASSERT_SVH
`define MULTISPECIES_BGK_GUO_COLLISION_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MSBGK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MSBGK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/msbgk_pkg.sv */
// Shared types, codes and lattice tables for the multispecies BGK collision block.
package msbgk_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [3:0] t_tau;

    localparam t_kind KIND_ELEC = 2'd0;
    localparam t_kind KIND_ION  = 2'd1;
    localparam t_kind KIND_NEUT = 2'd2;
    localparam t_kind KIND_NONE = 2'd3;

    localparam logic [1:0] CFG_QM_ELEC = 2'd0;
    localparam logic [1:0] CFG_QM_ION  = 2'd1;
    localparam logic [1:0] CFG_INV_CS2 = 2'd2;

    // tau selector
    localparam logic [1:0] TSEL_OWN    = 2'd0;
    localparam logic [1:0] TSEL_FIRST  = 2'd1;
    localparam logic [1:0] TSEL_SECOND = 2'd2;
    localparam logic [1:0] TSEL_FORCE  = 2'd3;

    function automatic t_tau f_tau(input t_kind kind, input logic [1:0] sel);
        t_tau t;
        t = 4'd1;
        case (kind)
            KIND_ELEC: begin
                case (sel)
                    TSEL_OWN:    t = 4'd5;
                    TSEL_FIRST:  t = 4'd6;
                    TSEL_SECOND: t = 4'd4;
                    default:     t = 4'd10;
                endcase
            end
            KIND_ION: begin
                case (sel)
                    TSEL_OWN:    t = 4'd3;
                    TSEL_FIRST:  t = 4'd6;
                    TSEL_SECOND: t = 4'd2;
                    default:     t = 4'd6;
                endcase
            end
            KIND_NEUT: begin
                case (sel)
                    TSEL_OWN:    t = 4'd1;
                    TSEL_FIRST:  t = 4'd4;
                    TSEL_SECOND: t = 4'd2;
                    default:     t = 4'd2;
                endcase
            end
            default: t = 4'd1;
        endcase
        return t;
    endfunction

    // {cx, cy}, each two-bit signed; unknown codes are the rest velocity
    function automatic logic [3:0] f_cvel(input logic [3:0] code);
        logic [3:0] v;
        v = 4'b0000;
        case (code)
            4'd0:    v = 4'b1111;
            4'd1:    v = 4'b1100;
            4'd2:    v = 4'b1101;
            4'd3:    v = 4'b0011;
            4'd4:    v = 4'b0000;
            4'd5:    v = 4'b0001;
            4'd6:    v = 4'b0111;
            4'd7:    v = 4'b0100;
            4'd8:    v = 4'b0101;
            default: v = 4'b0000;
        endcase
        return v;
    endfunction

endpackage

/* hdl/multispecies_bgk_guo_collision.sv */
// Top level: eight-stage BGK collision with Guo electric forcing for three species.
//
// Usage notes
// - Input words arrive on the s_axis group. tuser carries the species kind
//   (0 electron, 1 ion, 2 neutral, 3 pass-through). tdata carries the
//   population, three equilibria, density, velocity, field, velocity code
//   and lattice weight, packed from the lowest bit up.
// - Result words leave on the m_axis group: tdata holds the post-collision
//   population, tuser[0] is set when any step clipped to the Q range.
// - Eight register stages, the first loaded on the accepting edge; one word
//   per cycle is taken in steady state while i_m_axis_tready stays high.
//   The depth is set by the serial chain of four fixed-point products on
//   the forcing path plus the two-stage reciprocal divide by 2 tau_own.
// - Config writes (q/m per charged species, 1/cs^2) via i_cfg_we only when
//   the pipe is empty; taken on the same edge, no read-back.
// - On stall (i_m_axis_tready low with a word waiting) the whole pipe
//   freezes, o_s_axis_tready drops; nothing is lost or repeated. While the
//   output stage is empty the pipe keeps moving and bubbles flow out.
// - Synchronous active-low reset clears valid bits and loads config registers with defaults.
module multispecies_bgk_guo_collision
    import msbgk_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // dist_in, eq_self, eq_cross_first, eq_cross_second, density, vel_x,
    // vel_y, field_x, field_y, lattice_velocity, weight, zero pad
    input  logic [((9*DATA_WIDTH+FRAC_BITS+5+7)/8)*8-1:0] i_s_axis_tdata,
    // kind
    input  logic [1:0]          i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // post_value, zero pad
    output logic [((DATA_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // saturated
    output logic [0:0]          o_m_axis_tuser,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_wdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int OUT_W = ((DW + 7) / 8) * 8;
    localparam int SH    = DW + 4;
    localparam int RW    = SH + 1;
    localparam int PW    = DW + RW;

    localparam logic [RW-1:0] P2S = RW'(1) << SH;
    localparam logic [RW-1:0] R1  = P2S;
    localparam logic [RW-1:0] R2  = P2S / 2;
    localparam logic [RW-1:0] R3  = P2S / 3;
    localparam logic [RW-1:0] R4  = P2S / 4;
    localparam logic [RW-1:0] R5  = P2S / 5;
    localparam logic [RW-1:0] R6  = P2S / 6;
    localparam logic [RW-1:0] R10 = P2S / 10;

    localparam logic [2*DW:0]  HALF  = (2*DW+1)'(1) << (FB - 1);
    localparam logic [DW-1:0]  VMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]  VMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]  ONE_FX = DW'(1) << FB;
    localparam logic [DW-2:0]  ICS_RST = (DW-1)'(3) << FB;

    typedef struct packed {
        logic          neg;
        logic [DW-1:0] n;
        logic [DW-1:0] q0;
        t_tau          t;
    } t_div;

    // ---------------- arithmetic helpers, {flag, value} ----------------
    function automatic logic [DW:0] f_clip(input logic [DW:0] x);
        logic [DW:0] r;
        if (x[DW] != x[DW-1]) begin
            r = {1'b1, (x[DW] ? VMIN : VMAX)};
        end else begin
            r = {1'b0, x[DW-1:0]};
        end
        return r;
    endfunction

    function automatic logic [DW:0] f_sadd(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return f_clip({a[DW-1], a} + {b[DW-1], b});
    endfunction

    function automatic logic [DW:0] f_ssub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return f_clip({a[DW-1], a} - {b[DW-1], b});
    endfunction

    function automatic logic [DW:0] f_cmul(input logic [1:0] c, input logic [DW-1:0] a);
        logic [DW:0] r;
        r = '0;
        if (c == 2'b01) begin
            r = {1'b0, a};
        end else if (c == 2'b11) begin
            r = f_ssub('0, a);
        end
        return r;
    endfunction

    // product rounded half away from zero, clipped
    function automatic logic [DW:0] f_fmul(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic            neg;
        logic [DW-1:0]   ma;
        logic [DW-1:0]   mb;
        logic [2*DW:0]   p;
        logic [2*DW-FB:0] r;
        logic [DW-1:0]   lim;
        logic [DW-1:0]   m;
        logic            fl;
        neg = a[DW-1] ^ b[DW-1];
        ma  = a[DW-1] ? (~a + DW'(1)) : a;
        mb  = b[DW-1] ? (~b + DW'(1)) : b;
        p   = ((2*DW+1)'(ma) * (2*DW+1)'(mb)) + HALF;
        r   = p[2*DW:FB];
        lim = VMAX + DW'(neg);
        fl  = r > (2*DW-FB+1)'(lim);
        m   = fl ? lim : r[DW-1:0];
        return {fl, (neg ? (~m + DW'(1)) : m)};
    endfunction

    function automatic logic [RW-1:0] f_recip(input t_tau t);
        logic [RW-1:0] r;
        case (t)
            4'd2:    r = R2;
            4'd3:    r = R3;
            4'd4:    r = R4;
            4'd5:    r = R5;
            4'd6:    r = R6;
            4'd10:   r = R10;
            default: r = R1;
        endcase
        return r;
    endfunction

    // divide by small tau: reciprocal estimate (low by at most one)
    function automatic t_div f_div_a(input logic [DW-1:0] a, input t_tau t);
        t_div          d;
        logic [PW-1:0] prod;
        d.neg = a[DW-1];
        d.t   = t;
        d.n   = (a[DW-1] ? (~a + DW'(1)) : a) + DW'(t >> 1);
        prod  = PW'(d.n) * PW'(f_recip(t));
        d.q0  = prod[SH +: DW];
        return d;
    endfunction

    // correction step and sign
    function automatic logic [DW-1:0] f_div_b(input t_div d);
        logic [DW+3:0] qt;
        logic [DW-1:0] rem;
        logic [DW-1:0] q;
        qt  = (DW+4)'(d.q0) * (DW+4)'(d.t);
        rem = d.n - qt[DW-1:0];
        q   = (rem >= DW'(d.t)) ? d.q0 + DW'(1) : d.q0;
        return d.neg ? (~q + DW'(1)) : q;
    endfunction

    // ---------------- config registers ----------------
    logic [DW-1:0] r_qm_e;
    logic [DW-1:0] r_qm_i;
    logic [DW-2:0] r_ics;
    logic [DW-1:0] ics;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm_e <= ~ONE_FX + DW'(1);
            r_qm_i <= ONE_FX;
            r_ics  <= ICS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QM_ELEC: r_qm_e <= i_cfg_wdata;
                CFG_QM_ION:  r_qm_i <= i_cfg_wdata;
                CFG_INV_CS2: r_ics  <= i_cfg_wdata[DW-2:0];
                default: ;
            endcase
        end
    end

    assign ics = {1'b0, r_ics};

    // ---------------- flow control ----------------
    logic [8:1] r_v;
    logic       en;

    assign en              = !r_v[8] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[7:1], i_s_axis_tvalid};
        end
    end

    // ---------------- input unpack ----------------
    logic [DW-1:0] in_f, in_e0, in_e1, in_e2, in_rho, in_ux, in_uy, in_ex, in_ey;
    logic [3:0]    in_code;
    logic [FB:0]   in_w;
    t_kind         in_kind;

    assign in_f    = i_s_axis_tdata[0*DW +: DW];
    assign in_e0   = i_s_axis_tdata[1*DW +: DW];
    assign in_e1   = i_s_axis_tdata[2*DW +: DW];
    assign in_e2   = i_s_axis_tdata[3*DW +: DW];
    assign in_rho  = i_s_axis_tdata[4*DW +: DW];
    assign in_ux   = i_s_axis_tdata[5*DW +: DW];
    assign in_uy   = i_s_axis_tdata[6*DW +: DW];
    assign in_ex   = i_s_axis_tdata[7*DW +: DW];
    assign in_ey   = i_s_axis_tdata[8*DW +: DW];
    assign in_code = i_s_axis_tdata[9*DW +: 4];
    assign in_w    = i_s_axis_tdata[9*DW+4 +: FB+1];
    assign in_kind = i_s_axis_tuser;

    // ---------------- stage 1: differences, c.E, c.u, first products ----------------
    t_kind         r1_kind;
    logic [DW-1:0] r1_f, r1_d0, r1_d1, r1_d2, r1_ce, r1_cu, r1_wq, r1_rho, r1_px, r1_py;
    logic          r1_fe, r1_ff;
    logic [DW:0]   s1_d0, s1_d1, s1_d2, s1_cex, s1_cey, s1_cux, s1_cuy, s1_ce, s1_cu;
    logic [DW:0]   s1_wq, s1_px, s1_py;
    logic [3:0]    s1_cv;
    logic [DW-1:0] s1_qm;

    always_comb begin
        s1_cv  = f_cvel(in_code);
        s1_qm  = (in_kind == KIND_ION) ? r_qm_i : r_qm_e;
        s1_d0  = f_ssub(in_e0, in_f);
        s1_d1  = f_ssub(in_e1, in_f);
        s1_d2  = f_ssub(in_e2, in_f);
        s1_cex = f_cmul(s1_cv[3:2], in_ex);
        s1_cey = f_cmul(s1_cv[1:0], in_ey);
        s1_cux = f_cmul(s1_cv[3:2], in_ux);
        s1_cuy = f_cmul(s1_cv[1:0], in_uy);
        s1_ce  = f_sadd(s1_cex[DW-1:0], s1_cey[DW-1:0]);
        s1_cu  = f_sadd(s1_cux[DW-1:0], s1_cuy[DW-1:0]);
        s1_wq  = f_fmul(DW'(in_w), s1_qm);
        s1_px  = f_fmul(in_ux, in_ex);
        s1_py  = f_fmul(in_uy, in_ey);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= in_kind;
            r1_f    <= in_f;
            r1_d0   <= s1_d0[DW-1:0];
            r1_d1   <= s1_d1[DW-1:0];
            r1_d2   <= s1_d2[DW-1:0];
            r1_ce   <= s1_ce[DW-1:0];
            r1_cu   <= s1_cu[DW-1:0];
            r1_wq   <= s1_wq[DW-1:0];
            r1_rho  <= in_rho;
            r1_px   <= s1_px[DW-1:0];
            r1_py   <= s1_py[DW-1:0];
            r1_fe   <= s1_d0[DW] | s1_d1[DW] | s1_d2[DW];
            r1_ff   <= s1_cex[DW] | s1_cey[DW] | s1_cux[DW] | s1_cuy[DW] | s1_ce[DW]
                     | s1_cu[DW] | s1_wq[DW] | s1_px[DW] | s1_py[DW];
        end
    end

    // ---------------- stage 2: cu*ce, wq*rho, u.E, tau estimates ----------------
    t_kind         r2_kind;
    logic [DW-1:0] r2_f, r2_ce, r2_cuce, r2_wqr, r2_ue;
    t_div          r2_q0, r2_q1, r2_q2;
    logic          r2_fe, r2_ff;
    logic [DW:0]   s2_cuce, s2_wqr, s2_ue;

    always_comb begin
        s2_cuce = f_fmul(r1_cu, r1_ce);
        s2_wqr  = f_fmul(r1_wq, r1_rho);
        s2_ue   = f_sadd(r1_px, r1_py);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind <= r1_kind;
            r2_f    <= r1_f;
            r2_ce   <= r1_ce;
            r2_cuce <= s2_cuce[DW-1:0];
            r2_wqr  <= s2_wqr[DW-1:0];
            r2_ue   <= s2_ue[DW-1:0];
            r2_q0   <= f_div_a(r1_d0, f_tau(r1_kind, TSEL_OWN));
            r2_q1   <= f_div_a(r1_d1, f_tau(r1_kind, TSEL_FIRST));
            r2_q2   <= f_div_a(r1_d2, f_tau(r1_kind, TSEL_SECOND));
            r2_fe   <= r1_fe;
            r2_ff   <= r1_ff | s2_cuce[DW] | s2_wqr[DW] | s2_ue[DW];
        end
    end

    // ---------------- stage 3: scale by 1/cs^2, finish relaxation terms ----------------
    t_kind         r3_kind;
    logic [DW-1:0] r3_f, r3_ce, r3_bm, r3_pre, r3_ue, r3_t0, r3_t1, r3_t2;
    logic          r3_fe, r3_ff;
    logic [DW:0]   s3_bm, s3_pre;

    always_comb begin
        s3_bm  = f_fmul(r2_cuce, ics);
        s3_pre = f_fmul(r2_wqr, ics);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_kind <= r2_kind;
            r3_f    <= r2_f;
            r3_ce   <= r2_ce;
            r3_ue   <= r2_ue;
            r3_bm   <= s3_bm[DW-1:0];
            r3_pre  <= s3_pre[DW-1:0];
            r3_t0   <= f_div_b(r2_q0);
            r3_t1   <= f_div_b(r2_q1);
            r3_t2   <= f_div_b(r2_q2);
            r3_fe   <= r2_fe;
            r3_ff   <= r2_ff | s3_bm[DW] | s3_pre[DW];
        end
    end

    // ---------------- stage 4: bracket and relaxed sum ----------------
    t_kind         r4_kind;
    logic [DW-1:0] r4_pe, r4_br, r4_pre;
    logic          r4_fe, r4_ff;
    logic [DW:0]   s4_b1, s4_br, s4_p1, s4_p2, s4_p3;

    always_comb begin
        s4_b1 = f_sadd(r3_ce, r3_bm);
        s4_br = f_ssub(s4_b1[DW-1:0], r3_ue);
        s4_p1 = f_sadd(r3_f, r3_t0);
        s4_p2 = f_sadd(s4_p1[DW-1:0], r3_t1);
        s4_p3 = f_sadd(s4_p2[DW-1:0], r3_t2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_kind <= r3_kind;
            r4_br   <= s4_br[DW-1:0];
            r4_pre  <= r3_pre;
            r4_ff   <= r3_ff | s4_b1[DW] | s4_br[DW];
            // pass-through kind keeps the population untouched and unflagged
            if (r3_kind == KIND_NONE) begin
                r4_pe <= r3_f;
                r4_fe <= 1'b0;
            end else begin
                r4_pe <= s4_p3[DW-1:0];
                r4_fe <= r3_fe | s4_p1[DW] | s4_p2[DW] | s4_p3[DW];
            end
        end
    end

    // ---------------- stage 5: g = pre * bracket ----------------
    t_kind         r5_kind;
    logic [DW-1:0] r5_pe, r5_g;
    logic          r5_fe, r5_ff;
    logic [DW:0]   s5_g;

    assign s5_g = f_fmul(r4_pre, r4_br);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_kind <= r4_kind;
            r5_pe   <= r4_pe;
            r5_g    <= s5_g[DW-1:0];
            r5_fe   <= r4_fe;
            r5_ff   <= r4_ff | s5_g[DW];
        end
    end

    // ---------------- stage 6/7: g / (2 tau_own) ----------------
    t_kind         r6_kind;
    logic [DW-1:0] r6_pe, r6_g;
    t_div          r6_q;
    logic          r6_fe, r6_ff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_kind <= r5_kind;
            r6_pe   <= r5_pe;
            r6_g    <= r5_g;
            r6_q    <= f_div_a(r5_g, f_tau(r5_kind, TSEL_FORCE));
            r6_fe   <= r5_fe;
            r6_ff   <= r5_ff;
        end
    end

    t_kind         r7_kind;
    logic [DW-1:0] r7_pe, r7_g, r7_dg;
    logic          r7_fe, r7_ff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_kind <= r6_kind;
            r7_pe   <= r6_pe;
            r7_g    <= r6_g;
            r7_dg   <= f_div_b(r6_q);
            r7_fe   <= r6_fe;
            r7_ff   <= r6_ff;
        end
    end

    // ---------------- stage 8: add forcing, output register ----------------
    logic [DW-1:0] r8_post;
    logic          r8_sat;
    logic [DW:0]   s8_fo, s8_po;
    logic          s8_charged;

    always_comb begin
        s8_fo      = f_ssub(r7_g, r7_dg);
        s8_po      = f_sadd(r7_pe, s8_fo[DW-1:0]);
        s8_charged = (r7_kind == KIND_ELEC) || (r7_kind == KIND_ION);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (s8_charged) begin
                r8_post <= s8_po[DW-1:0];
                r8_sat  <= r7_fe | r7_ff | s8_fo[DW] | s8_po[DW];
            end else begin
                r8_post <= r7_pe;
                r8_sat  <= r7_fe;
            end
        end
    end

    assign o_m_axis_tvalid   = r_v[8];
    assign o_m_axis_tdata    = OUT_W'(r8_post);
    assign o_m_axis_tuser[0] = r8_sat;

    // ---------------- checks ----------------
`include "multispecies_bgk_guo_collision_assert.svh"

    `MSBGK_ASSERT_NEXT(a_stall_freezes, r_v[8] && !i_m_axis_tready, $stable(r_v), "pipe moved during stall")
    `MSBGK_ASSERT_NOW(a_pass_unflagged, r_v[4] && r4_kind == KIND_NONE, !r4_fe, "pass-through word flagged")
    `MSBGK_ASSERT_NEXT(a_drain, en && r_v[7], o_m_axis_tvalid, "word lost before output stage")

endmodule

/* dv/multispecies_bgk_guo_collision_checker.sv */
// Checker for the BGK collision block: predicts each result and compares.
module multispecies_bgk_guo_collision_checker
    import msbgk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [311:0] i_in_data,
    input  logic [1:0]   i_in_kind,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [31:0]  i_out_data,
    input  logic [0:0]   i_out_sat,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } t_post;

    t_post post_q[$];
    longint qm_elec, qm_ion, ics;
    bit clip;

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (s > QMAX) begin clip = 1'b1; return QMAX; end
        if (s < QMIN) begin clip = 1'b1; return QMIN; end
        return s;
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return add_sat(a, -b);
    endfunction

    // round half away from zero
    function automatic longint div_round(longint a, int t);
        longint m;
        m = (a < 0) ? -a : a;
        m = (m + t / 2) / t;
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        bit neg;
        longint lim;
        neg = (a < 0) != (b < 0);
        p = 128'(a) * 128'(b);
        m = (p < 0) ? -p : p;
        m = (m + (128'd1 << 15)) >> 16;
        lim = neg ? -QMIN : QMAX;
        if (m > 128'(lim)) begin clip = 1'b1; m = 128'(lim); end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint c_mul(int c, longint a);
        if (c > 0) return a;
        if (c < 0) return sub_sat(0, a);
        return 0;
    endfunction

    function automatic t_post collide(logic [1:0] kind, logic [311:0] d);
        longint f, e0, e1, e2, rho, ux, uy, ex, ey, w, qm, post;
        longint ce, cu, ue, br, pre, g;
        int cx, cy, t0, t1, t2;
        logic [3:0] code;
        t_post r;
        clip = 1'b0;
        f = longint'($signed(d[31:0]));     e0 = longint'($signed(d[63:32]));
        e1 = longint'($signed(d[95:64]));   e2 = longint'($signed(d[127:96]));
        rho = longint'($signed(d[159:128])); ux = longint'($signed(d[191:160]));
        uy = longint'($signed(d[223:192])); ex = longint'($signed(d[255:224]));
        ey = longint'($signed(d[287:256])); code = d[291:288];
        w = longint'(d[308:292]);
        if (kind == KIND_NONE) begin
            r.value = d[31:0];
            r.sat = 1'b0;
            return r;
        end
        cx = 0; cy = 0;
        if (code <= 8) begin cx = code / 3 - 1; cy = code % 3 - 1; end
        case (kind)
            KIND_ELEC: begin t0 = 5; t1 = 6; t2 = 4; end
            KIND_ION:  begin t0 = 3; t1 = 6; t2 = 2; end
            default:   begin t0 = 1; t1 = 4; t2 = 2; end
        endcase
        post = add_sat(f, div_round(sub_sat(e0, f), t0));
        post = add_sat(post, div_round(sub_sat(e1, f), t1));
        post = add_sat(post, div_round(sub_sat(e2, f), t2));
        if (kind != KIND_NEUT) begin
            qm = (kind == KIND_ELEC) ? qm_elec : qm_ion;
            ce = add_sat(c_mul(cx, ex), c_mul(cy, ey));
            cu = add_sat(c_mul(cx, ux), c_mul(cy, uy));
            ue = add_sat(fix_mul(ux, ex), fix_mul(uy, ey));
            br = add_sat(ce, fix_mul(fix_mul(cu, ce), ics));
            br = sub_sat(br, ue);
            pre = fix_mul(fix_mul(fix_mul(w, qm), rho), ics);
            g = fix_mul(pre, br);
            post = add_sat(post, sub_sat(g, div_round(g, 2 * t0)));
        end
        r.value = post[31:0];
        r.sat = clip;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_post exp_post;
        if (!i_rst_n) begin
            qm_elec <= -65536;
            qm_ion <= 65536;
            ics <= 196608;
            post_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_QM_ELEC: qm_elec <= longint'($signed(i_cfg_wdata));
                    CFG_QM_ION:  qm_ion <= longint'($signed(i_cfg_wdata));
                    CFG_INV_CS2: ics <= longint'(i_cfg_wdata[30:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                post_q.push_back(collide(i_in_kind, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (post_q.size() == 0) begin
                    $error("unexpected result word %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_post = post_q.pop_front();
                    if (i_out_data !== exp_post.value) begin
                        $error("post_value expected %h actual %h",
                               exp_post.value, i_out_data);
                        o_errors <= o_errors + 1;
                    end else if (i_out_sat[0] !== exp_post.sat) begin
                        $error("saturated expected %b actual %b",
                               exp_post.sat, i_out_sat[0]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= post_q.size();
        end
    end
endmodule

/* dv/multispecies_bgk_guo_collision_tb.sv */
// Testbench top: stimulus, configuration phases and verdict for the BGK collision block.
module multispecies_bgk_guo_collision_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msbgk_pkg::*;

    localparam int WATCHDOG = 20000;

    logic         clk, rst_n;
    logic         s_valid, s_ready, m_valid, m_ready;
    logic [311:0] s_data;
    logic [1:0]   s_kind;
    logic [31:0]  m_data;
    logic [0:0]   m_sat;
    logic         cfg_we;
    logic [1:0]   cfg_idx;
    logic [31:0]  cfg_wdata;
    int           errors, pending, idle_cycles;
    bit           hold_off;   // long receiver hold-off request

    multispecies_bgk_guo_collision dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_kind),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_sat),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    multispecies_bgk_guo_collision_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_in_kind(s_kind), .i_out_valid(m_valid), .i_out_ready(m_ready),
        .i_out_data(m_data), .i_out_sat(m_sat), .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stall pattern, with calm stretches and one long hold-off.
    initial begin
        int mode, n;
        m_ready = 0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (60) @(posedge clk);
                hold_off = 0;
            end
            if (n == 0) begin
                mode = $urandom_range(0, 3);
                n = $urandom_range(5, 60);
            end
            n--;
            case (mode)
                0: m_ready <= 1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: cycles with no word moving on either side.
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("multispecies_bgk_guo_collision_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_q(int style);
        case (style)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic logic [311:0] pack_word(logic [31:0] q[9], logic [3:0] code,
                                             logic [16:0] w);
        logic [311:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*32 +: 32] = q[i];
        d[291:288] = code;
        d[308:292] = w;
        return d;
    endfunction

    task automatic send_word(logic [1:0] kind, logic [311:0] d);
        s_valid <= 1;
        s_kind <= kind;
        s_data <= d;
        do @(posedge clk); while (!s_ready);
    endtask

    task automatic send_random(logic [1:0] kind, int style);
        logic [31:0] q[9];
        logic [16:0] w;
        for (int i = 0; i < 9; i++) q[i] = rand_q($urandom_range(0, 3) == 0 ? 0 : style);
        case ($urandom_range(0, 3))
            0: w = 17'($urandom_range(0, 65536));
            1: w = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            2: w = 17'($urandom());
            default: w = 17'($urandom_range(0, 30000));
        endcase
        send_word(kind, pack_word(q, 4'($urandom_range(0, 15)), w));
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    initial begin
        logic [31:0] q[9];
        logic [31:0] qe[6], qi[6], ic[6];
        int burst;
        s_valid = 0; s_data = '0; s_kind = KIND_ELEC;
        cfg_we = 0; cfg_idx = CFG_QM_ELEC; cfg_wdata = '0;
        hold_off = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every kind, field extremes, every velocity code, pass-through
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) q[i] = 32'h7fffffff;
            send_word(2'(k), pack_word(q, 4'd8, 17'd65536));
            for (int i = 0; i < 9; i++) q[i] = 32'h80000000;
            send_word(2'(k), pack_word(q, 4'd0, 17'd65536));
        end
        for (int c = 0; c < 16; c++) begin
            for (int i = 0; i < 9; i++) q[i] = rand_q(2);
            send_word(2'(c % 3), pack_word(q, 4'(c), 17'd16384));
        end
        drain();

        // configuration phases, extremes included
        qe = '{32'hffff0000, 32'h80000000, 32'h7fffffff, 32'h0, 32'hfff00000, 32'h00001000};
        qi = '{32'h00010000, 32'h7fffffff, 32'h80000000, 32'h0, 32'h00100000, 32'hffffe000};
        ic = '{32'h00030000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffffffff, 32'h00008000};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_QM_ELEC, qe[ph]);
            write_reg(CFG_QM_ION, qi[ph]);
            write_reg(CFG_INV_CS2, ic[ph]);
            write_reg(2'd3, $urandom());   // unused index, must be ignored
            for (int n = 0; n < 265;) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 265; b++, n++) begin
                    if (ph == 2 && n == 40) hold_off = 1;
                    send_random(2'($urandom_range(0, 7) == 0 ? 3 : $urandom_range(0, 2)),
                                $urandom_range(0, 3));
                end
                s_valid <= 0;
                if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 8)) @(posedge clk);
                else @(posedge clk);
            end
            drain();
        end

        if (errors == 0)
            $display("multispecies_bgk_guo_collision_tb: PASS");
        else
            $display("multispecies_bgk_guo_collision_tb: FAIL");
        $finish;
    end
endmodule

/* multispecies_bgk_guo_collision.f */
+incdir+hdl
hdl/msbgk_pkg.sv
hdl/multispecies_bgk_guo_collision.sv
dv/multispecies_bgk_guo_collision_checker.sv
dv/multispecies_bgk_guo_collision_tb.sv
